FILE: hw/rtl/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and round functions for the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } state_e;

  localparam logic [7:0]  PadByte   = 8'h80;
  localparam logic [5:0]  LenOffset = 6'd56;

  localparam logic [31:0] HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct packed {
    logic [7:0] data_byte;
    logic       carries_byte;
    logic       finish;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

FILE: hw/rtl/sha256_if.sv
// ----------------------------------------------------------------------------
// SHA-256 stream interfaces
// Valid/ready channels for input items and digest words.
// ----------------------------------------------------------------------------
interface sha256_in_if;
  logic                  valid;
  logic                  ready;
  sha256_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sha256_out_if;
  logic                  valid;
  logic                  ready;
  sha256_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-serial SHA-256 with one shared round datapath.
// ----------------------------------------------------------------------------
// Byte items are taken one per cycle while idle; the 64th byte of a block starts the
// compression: a load step, 64 rounds over the single shared round
// unit with a rolling 16-word message schedule, and a fold into
// the chaining hash (not ready meanwhile). A finishing item pads
// one byte per cycle (a second block when the length spills into it)
// and then shows eight digest words, one per accepted request.
module sha256_stream_hasher (
  input  logic         clk_i,
  input  logic         rst_ni,
  sha256_in_if.sink    in_i,
  sha256_out_if.source out_o
);

  sha256_pkg::state_e state_q, state_d;

  logic [31:0] hash_q [8];
  logic [31:0] work_q [8];
  logic [31:0] w_q [16];
  logic [5:0]  fill_q;
  logic [63:0] bits_q, len_q;
  logic [5:0]  rnd_q;
  logic        fin_q;
  logic [2:0]  oidx_q;
  logic        pad_mode_q; // message is being padded
  logic        spill_q;    // pad byte landed in the length field

  // one byte to write into the block this cycle
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [31:0] t1, t2, w_new;
  logic [2:0]  len_sel;

  assign t1 = work_q[7] + sha256_pkg::big_sig1(work_q[4])
            + ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
            + sha256_pkg::RoundK[rnd_q] + w_q[0];
  assign t2 = sha256_pkg::big_sig0(work_q[0])
            + ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));
  assign w_new = w_q[0] + sha256_pkg::small_sig0(w_q[1]) + w_q[9]
               + sha256_pkg::small_sig1(w_q[14]);
  assign len_sel = fill_q[2:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_byte = in_i.payload.data_byte;
    unique case (state_q)
      sha256_pkg::ST_IDLE: wr_en = in_i.valid && in_i.payload.carries_byte;
      sha256_pkg::ST_PAD: begin
        wr_en = 1'b1;
        priority if (fin_q) begin
          wr_byte = sha256_pkg::PadByte;
        end else if (fill_q >= sha256_pkg::LenOffset && !spill_q) begin
          wr_byte = len_q[{3'd7 - len_sel, 3'b000} +: 8];
        end else begin
          wr_byte = 8'h00;
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sha256_pkg::ST_IDLE: begin
        if (in_i.valid) begin
          priority if (wr_en && fill_q == 6'd63) state_d = sha256_pkg::ST_INIT;
          else if (in_i.payload.finish)         state_d = sha256_pkg::ST_PAD;
        end
      end
      sha256_pkg::ST_PAD:   if (fill_q == 6'd63) state_d = sha256_pkg::ST_INIT;
      sha256_pkg::ST_INIT:  state_d = sha256_pkg::ST_ROUND;
      sha256_pkg::ST_ROUND: if (rnd_q == 6'd63) state_d = sha256_pkg::ST_ADD;
      sha256_pkg::ST_ADD: begin
        // idle mid-message; pad again if the pad byte is pending or the length spilled, else output
        priority if (!pad_mode_q)     state_d = sha256_pkg::ST_IDLE;
        else if (fin_q || spill_q)    state_d = sha256_pkg::ST_PAD;
        else                          state_d = sha256_pkg::ST_OUT;
      end
      sha256_pkg::ST_OUT: if (out_o.ready && oidx_q == 3'd7) state_d = sha256_pkg::ST_IDLE;
      default: state_d = sha256_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_i.ready                  = (state_q == sha256_pkg::ST_IDLE);
    out_o.valid                 = (state_q == sha256_pkg::ST_OUT);
    out_o.payload.digest_word   = hash_q[oidx_q];
    out_o.payload.word_index    = oidx_q;
    out_o.payload.last_word     = (oidx_q == 3'd7);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sha256_pkg::ST_IDLE;
      fill_q     <= '0;
      bits_q     <= '0;
      len_q      <= '0;
      fin_q      <= 1'b0;
      pad_mode_q <= 1'b0;
      spill_q    <= 1'b0;
      rnd_q      <= '0;
      oidx_q     <= '0;
      hash_q     <= sha256_pkg::HashInit;
    end else begin
      state_q <= state_d;
      if (wr_en) begin
        w_q[fill_q[5:2]][{2'd3 - fill_q[1:0], 3'b000} +: 8] <= wr_byte;
        fill_q <= fill_q + 6'd1;
      end
      unique case (state_q)
        sha256_pkg::ST_IDLE: begin
          if (in_i.valid) begin
            if (in_i.payload.carries_byte) bits_q <= bits_q + 64'd8;
            if (in_i.payload.finish) begin
              fin_q      <= 1'b1;
              pad_mode_q <= 1'b1;
              len_q      <= in_i.payload.carries_byte ? bits_q + 64'd8 : bits_q;
            end
          end
        end
        sha256_pkg::ST_PAD: begin
          if (fin_q) begin
            fin_q <= 1'b0;
            if (fill_q >= sha256_pkg::LenOffset) spill_q <= 1'b1;
          end
        end
        sha256_pkg::ST_INIT: begin
          work_q <= hash_q;
          rnd_q  <= '0;
        end
        sha256_pkg::ST_ROUND: begin
          work_q[7] <= work_q[6];
          work_q[6] <= work_q[5];
          work_q[5] <= work_q[4];
          work_q[4] <= work_q[3] + t1;
          work_q[3] <= work_q[2];
          work_q[2] <= work_q[1];
          work_q[1] <= work_q[0];
          work_q[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
          w_q[15] <= w_new;
          rnd_q   <= rnd_q + 6'd1;
        end
        sha256_pkg::ST_ADD: begin
          for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + work_q[i];
          oidx_q  <= '0;
          spill_q <= 1'b0;
        end
        sha256_pkg::ST_OUT: begin
          if (out_o.ready) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              hash_q     <= sha256_pkg::HashInit;
              bits_q     <= '0;
              pad_mode_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/sha256_checker.sv
// ----------------------------------------------------------------------------
// SHA-256 port checker
// Port-level properties of the stream hasher, bound to the hasher module.
// ----------------------------------------------------------------------------
module sha256_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] word_index,
  input logic       last_word
);

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word mismatch");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid && in_ready))
    else $error("input taken while digest pending");

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready && !last_word) |=> (out_valid && word_index == $past(word_index) + 3'd1))
    else $error("digest word order");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(word_index)))
    else $error("stalled request dropped");

endmodule

bind sha256_stream_hasher sha256_checker u_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready   (in_i.ready),
  .out_valid  (out_o.valid),
  .out_ready  (out_o.ready),
  .word_index (out_o.payload.word_index),
  .last_word  (out_o.payload.last_word)
);
